FILE: hdl/ncm_pkg.sv
// Shared constants for the normalization cube map texel generator.
`timescale 1ns / 1ps
`default_nettype none

package ncm_pkg;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam int ENC_BITS = 8;
    localparam int ENC_SQ_BITS = 2 * ENC_BITS;
    localparam logic [ENC_SQ_BITS-1:0] ENC_SCALE_SQ = 16'd65025;

endpackage

`default_nettype wire

FILE: hdl/normalization_cube_map_texel.sv
// Normalization cube map texel generator: face and texel address in, encoded RGB direction out.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one texel request per clock; busy stays low since the pipeline never
// stalls. The request is captured and its direction vector formed in the first
// stage, component squares come next, then the squared length and the scaled
// squared components. Each of the eight color bits is then settled by two
// stages (trial square, then one multiply and compare against the squared
// length); an output register then drives o_strobe and the color, and results
// leave at one per clock. Faces six and seven give all-zero color.
module normalization_cube_map_texel #(
    parameter int FACE_SIZE = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_face,
    input  wire logic [4:0] i_column,
    input  wire logic [4:0] i_row,
    output logic            o_strobe,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    localparam int EB      = ncm_pkg::ENC_BITS;
    localparam int SB      = ncm_pkg::ENC_SQ_BITS;
    localparam int MAG_MAX = (FACE_SIZE > 63) ? FACE_SIZE : 63;
    localparam int MW      = $clog2(MAG_MAX + 1);
    localparam int IW      = MW + 2;
    localparam int CSW     = 2 * MW;
    localparam int QW      = 2 * MW + 2;
    localparam int BSW     = CSW + SB;
    localparam int LW      = QW + SB;

    localparam logic signed [IW-1:0] S_SIGNED = IW'(FACE_SIZE);
    localparam logic [MW-1:0]        S_MAG    = MW'(FACE_SIZE);

    typedef struct packed {
        logic [QW-1:0]           q;
        logic [2:0][BSW-1:0]     bsq;
        logic [2:0]              neg;
        logic                    bad;
        logic [2:0][EB-1:0]      pre;
    } t_ctx;

    logic                  accept;
    logic signed [IW-1:0]  u_s;
    logic signed [IW-1:0]  v_s;
    logic [MW-1:0]         u_mag;
    logic [MW-1:0]         v_mag;
    logic                  u_neg;
    logic                  v_neg;
    logic [2:0][MW-1:0]    n_mag;
    logic [2:0]            n_sgn;
    logic                  n_bad;

    logic                  r_v0;
    logic [2:0][MW-1:0]    r_mag0;
    logic [2:0]            r_neg0;
    logic                  r_bad0;

    logic                  r_v1;
    logic [2:0][CSW-1:0]   r_csq1;
    logic [2:0]            r_neg1;
    logic                  r_bad1;

    logic                  r_v2;
    t_ctx                  r_ctx2;

    logic [EB-1:0]         r_va;
    logic [EB-1:0]         r_vb;
    t_ctx                  r_actx [EB];
    t_ctx                  r_bctx [EB];
    logic [2:0][SB-1:0]    r_amsq [EB];
    logic [2:0]            r_aneg [EB];

    logic                  r_strobe;
    logic [2:0][EB-1:0]    r_rgb;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        u_s   = $signed({{(IW-6){1'b0}}, i_column, 1'b1}) - S_SIGNED;
        v_s   = $signed({{(IW-6){1'b0}}, i_row, 1'b1}) - S_SIGNED;
        u_neg = u_s[IW-1];
        v_neg = v_s[IW-1];
        u_mag = u_neg ? MW'(-u_s) : MW'(u_s);
        v_mag = v_neg ? MW'(-v_s) : MW'(v_s);
        n_bad = 1'b0;
        unique case (i_face)
            ncm_pkg::FACE_POS_X: begin
                n_mag = {u_mag, v_mag, S_MAG};
                n_sgn = {~u_neg, v_neg, 1'b0};
            end
            ncm_pkg::FACE_NEG_X: begin
                n_mag = {u_mag, v_mag, S_MAG};
                n_sgn = {u_neg, v_neg, 1'b1};
            end
            ncm_pkg::FACE_POS_Y: begin
                n_mag = {v_mag, S_MAG, u_mag};
                n_sgn = {v_neg, 1'b1, u_neg};
            end
            ncm_pkg::FACE_NEG_Y: begin
                n_mag = {v_mag, S_MAG, u_mag};
                n_sgn = {~v_neg, 1'b0, u_neg};
            end
            ncm_pkg::FACE_POS_Z: begin
                n_mag = {S_MAG, v_mag, u_mag};
                n_sgn = {1'b0, v_neg, u_neg};
            end
            ncm_pkg::FACE_NEG_Z: begin
                n_mag = {S_MAG, v_mag, u_mag};
                n_sgn = {1'b1, v_neg, ~u_neg};
            end
            default: begin
                n_mag = '0;
                n_sgn = '0;
                n_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_mag0[j] <= n_mag[j];
            r_neg0[j] <= n_sgn[j] && (n_mag[j] != '0);
            r_csq1[j] <= CSW'(r_mag0[j]) * CSW'(r_mag0[j]);
            r_ctx2.bsq[j] <= BSW'(r_csq1[j]) * BSW'(ncm_pkg::ENC_SCALE_SQ);
        end
        r_bad0 <= n_bad;
        r_neg1 <= r_neg0;
        r_bad1 <= r_bad0;
        r_ctx2.q   <= QW'(r_csq1[0]) + QW'(r_csq1[1]) + QW'(r_csq1[2]);
        r_ctx2.neg <= r_neg1;
        r_ctx2.bad <= r_bad1;
        r_ctx2.pre <= '0;
    end

    for (genvar k = 0; k < EB; k++) begin : g_bit
        localparam logic [EB-1:0] BIT = EB'(1 << (EB - 1 - k));

        t_ctx               w_in;
        logic               w_vin;
        logic [2:0][EB-1:0] n_trial;
        logic [2:0][EB-1:0] n_am;
        logic [2:0][SB-1:0] n_amsq;
        logic [2:0][EB-1:0] b_trial;
        logic [2:0][LW-1:0] n_lhs;
        logic [2:0]         n_ok;
        t_ctx               n_bctx;

        if (k == 0) begin : g_first
            assign w_in  = r_ctx2;
            assign w_vin = r_v2;
        end else begin : g_next
            assign w_in  = r_bctx[k-1];
            assign w_vin = r_vb[k-1];
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                n_trial[j] = w_in.pre[j] | BIT;
                n_am[j]    = n_trial[j][EB-1] ? {n_trial[j][EB-2:0], 1'b1}
                                              : ~{n_trial[j][EB-2:0], 1'b0};
                n_amsq[j]  = SB'(n_am[j]) * SB'(n_am[j]);
            end
        end

        always_comb begin
            n_bctx = r_actx[k];
            for (int j = 0; j < 3; j++) begin
                b_trial[j] = r_actx[k].pre[j] | BIT;
                n_lhs[j]   = LW'(r_amsq[k][j]) * LW'(r_actx[k].q);
                if (r_aneg[k][j]) begin
                    n_ok[j] = r_actx[k].neg[j] ? (n_lhs[j] >= LW'(r_actx[k].bsq[j])) : 1'b1;
                end else begin
                    n_ok[j] = r_actx[k].neg[j] ? 1'b0 : (n_lhs[j] <= LW'(r_actx[k].bsq[j]));
                end
                n_bctx.pre[j] = n_ok[j] ? b_trial[j] : r_actx[k].pre[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[k] <= 1'b0;
                r_vb[k] <= 1'b0;
            end else begin
                r_va[k] <= w_vin;
                r_vb[k] <= r_va[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_actx[k] <= w_in;
            r_amsq[k] <= n_amsq;
            for (int j = 0; j < 3; j++) begin
                r_aneg[k][j] <= ~n_trial[j][EB-1];
            end
            r_bctx[k] <= n_bctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vb[EB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= r_bctx[EB-1].bad ? '0 : r_bctx[EB-1].pre;
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_rgb[0];
    assign o_green  = r_rgb[1];
    assign o_blue   = r_rgb[2];

    a_enter_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> r_va[0])
        else $error("request lost entering the bit stages");

    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb[3] |-> (((r_bctx[3].pre[0] | r_bctx[3].pre[1] | r_bctx[3].pre[2])
                      & 8'h0F) == 8'h00))
        else $error("undecided color bits set early");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb[EB-1] |=> o_strobe)
        else $error("finished request not strobed out");

    a_bad_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb[EB-1] && r_bctx[EB-1].bad) |=> (o_red == 8'h00 && o_green == 8'h00
                                               && o_blue == 8'h00))
        else $error("invalid face gave nonzero color");

endmodule

`default_nettype wire

FILE: dv/normalization_cube_map_texel_tb.sv
// Self-checking testbench for the normalization cube map texel generator.
`timescale 1ns / 1ps

module normalization_cube_map_texel_tb;

    localparam int FACE_SIZE = 32;
    localparam int HALF_PERIOD = 6;
    localparam int RANDOM_TEXELS = 1200;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam logic [2:0] FACE_BAD_LO = 3'd6;
    localparam logic [2:0] FACE_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0] face;
        logic [4:0] column;
        logic [4:0] row;
        int         gap;
        bit         drain;
    } t_texel_req;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] i_face = '0;
    logic [4:0] i_column = '0;
    logic [4:0] i_row = '0;
    wire logic       busy;
    wire logic       o_strobe;
    wire logic [7:0] o_red;
    wire logic [7:0] o_green;
    wire logic [7:0] o_blue;

    t_texel_req req_q[$];
    t_rgb       color_q[$];
    int         idle_left = 0;
    int         n_sent = 0;
    int         n_done = 0;
    int         n_reqs = 0;
    int         n_bad_faces = 0;
    int         n_errors = 0;

    normalization_cube_map_texel #(
        .FACE_SIZE(FACE_SIZE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_face  (i_face),
        .i_column(i_column),
        .i_row   (i_row),
        .o_strobe(o_strobe),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [7:0] encode_component(longint q, longint c);
        longint a;
        longint b;
        longint best;
        longint n;
        bit     fits;
        best = 0;
        for (n = 1; n <= 255; n++) begin
            a = 2 * n - 255;
            b = 255 * c;
            if (a < 0 && b >= 0) begin
                fits = 1'b1;
            end else if (a > 0 && b < 0) begin
                fits = 1'b0;
            end else if (a > 0) begin
                fits = (a * a * q) <= (b * b);
            end else begin
                fits = (a * a * q) >= (b * b);
            end
            if (fits) begin
                best = n;
            end
        end
        return best[7:0];
    endfunction

    function automatic t_rgb predict_texel(logic [2:0] face, logic [4:0] column,
                                           logic [4:0] row);
        longint s;
        longint u;
        longint v;
        longint x;
        longint y;
        longint z;
        longint q;
        t_rgb   color;
        s = FACE_SIZE;
        u = 2 * longint'(column) + 1 - s;
        v = 2 * longint'(row) + 1 - s;
        color = '{red: 8'd0, green: 8'd0, blue: 8'd0};
        case (face)
            ncm_pkg::FACE_POS_X: begin x = s;  y = v;  z = -u; end
            ncm_pkg::FACE_NEG_X: begin x = -s; y = v;  z = u;  end
            ncm_pkg::FACE_POS_Y: begin x = u;  y = -s; z = v;  end
            ncm_pkg::FACE_NEG_Y: begin x = u;  y = s;  z = -v; end
            ncm_pkg::FACE_POS_Z: begin x = u;  y = v;  z = s;  end
            ncm_pkg::FACE_NEG_Z: begin x = -u; y = v;  z = -s; end
            default: begin
                return color;
            end
        endcase
        q = x * x + y * y + z * z;
        color.red = encode_component(q, x);
        color.green = encode_component(q, y);
        color.blue = encode_component(q, z);
        return color;
    endfunction

    function automatic void add_req(logic [2:0] face, logic [4:0] column, logic [4:0] row,
                                    int gap, bit drain);
        req_q.push_back('{face: face, column: column, row: row, gap: gap, drain: drain});
        n_reqs++;
        if (face > ncm_pkg::FACE_NEG_Z) begin
            n_bad_faces++;
        end
    endfunction

    // driver: present one request at a time, hold start across back-to-back requests
    always @(posedge i_clk) begin
        t_texel_req req;
        logic       accepted;
        logic       next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            accepted = start && !busy;
            next_start = start && !accepted;
            if (accepted) begin
                color_q.push_back(predict_texel(i_face, i_column, i_row));
                n_sent <= n_sent + 1;
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                end else if (req_q.size() > 0) begin
                    if (!(req_q[0].drain && (accepted || n_sent != n_done))) begin
                        req = req_q.pop_front();
                        i_face <= req.face;
                        i_column <= req.column;
                        i_row <= req.row;
                        idle_left <= req.gap;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    // monitor: compare each strobed color with the oldest expectation
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_strobe) begin
            if (color_q.size() == 0) begin
                $error("result with no request waiting: red %0d green %0d blue %0d",
                       o_red, o_green, o_blue);
                n_errors++;
            end else begin
                want = color_q.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, actual %0d", want.red, o_red);
                    n_errors++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, actual %0d", want.green, o_green);
                    n_errors++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, actual %0d", want.blue, o_blue);
                    n_errors++;
                end
                n_done <= n_done + 1;
            end
        end
    end

    initial begin
        int       i;
        int       f;
        int       mode;
        int       gap;
        logic [2:0] face;
        for (f = ncm_pkg::FACE_POS_X; f <= FACE_BAD_HI; f++) begin
            add_req(f[2:0], 5'd0, 5'd0, $urandom_range(0, 10), 1'b0);
            add_req(f[2:0], 5'd31, 5'd31, $urandom_range(0, 10), 1'b0);
        end
        for (f = ncm_pkg::FACE_POS_X; f <= ncm_pkg::FACE_NEG_Z; f++) begin
            add_req(f[2:0], 5'd15, 5'd16, 0, 1'b0);
        end
        add_req(ncm_pkg::FACE_POS_Z, 5'd31, 5'd0, 0, 1'b0);
        add_req(ncm_pkg::FACE_NEG_Y, 5'd0, 5'd31, 0, 1'b0);
        add_req(ncm_pkg::FACE_NEG_X, 5'd16, 5'd15, $urandom_range(0, 10), 1'b0);

        for (i = 0; i < RANDOM_TEXELS; i++) begin
            mode = (i / 150) % 3;
            case (mode)
                0: gap = $urandom_range(0, 10);
                1: gap = 0;
                default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : 0;
            endcase
            if ($urandom_range(0, 15) == 0) begin
                face = 3'($urandom_range(FACE_BAD_LO, FACE_BAD_HI));
            end else begin
                face = 3'($urandom_range(ncm_pkg::FACE_POS_X, ncm_pkg::FACE_NEG_Z));
            end
            add_req(face, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), gap,
                    (i % 400) == 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_reqs || n_done != n_sent) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (color_q.size() != 0) begin
            $error("%0d expected colors never arrived", color_q.size());
            n_errors++;
        end
        $display("Checked %0d texel requests (%0d with face codes six and seven) on all faces,",
                 n_reqs, n_bad_faces);
        $display("corners and centers included, with random gaps, back-to-back runs and drains.");
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout after %0d ns with %0d of %0d requests checked",
                 RUN_LIMIT_NS, n_done, n_reqs);
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ncm_pkg.sv
hdl/normalization_cube_map_texel.sv
dv/normalization_cube_map_texel_tb.sv
